// ----- design/entropy_weighted_inner_product_top_macros.svh -----
// Assertion macros used by the datapath.
// Each macro is one concurrent check, clocked on clk and disabled in reset.
`ifndef ENTROPY_WEIGHTED_INNER_PRODUCT_TOP_MACROS_SVH
`define ENTROPY_WEIGHTED_INNER_PRODUCT_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define EWIP_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
`define EWIP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define EWIP_ASSERT_SAME(lbl, ante, cons)
`define EWIP_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- design/ewip_pkg.sv -----
// ----------------------------------------------------------------------------
// ewip_pkg
// Types, widths and helpers for the weighted inner product block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ewip_pkg;

    localparam int MAX_BINS_LOG2 = 24;
    localparam int MAX_TABLES    = 16;

    // Accumulator and kernel search widths.
    localparam int SQ_W    = 16 + MAX_BINS_LOG2;
    localparam int CROSS_W = 32 + MAX_BINS_LOG2;
    localparam int X_W     = CROSS_W + 16;
    localparam int XX_W    = 2 * X_W;
    localparam int P_W     = 2 * SQ_W;
    localparam int MUL_W   = X_W;
    localparam int MCNT_W  = $clog2(MUL_W + 1);
    localparam int RW      = XX_W + 2;
    localparam int TBL_W   = (MAX_TABLES > 1) ? $clog2(MAX_TABLES) : 1;
    localparam int ROOT_TOP = 30;

    localparam logic [31:0] ONE_Q31 = 32'h8000_0000;

    typedef struct packed {
        logic [7:0]  count_a;
        logic [7:0]  count_b;
        logic [15:0] bin_weight;
        logic        end_of_table;
        logic        end_of_all;
    } ewip_in_t;

    typedef struct packed {
        logic [31:0] table_kernel;
        logic [31:0] min_kernel;
        logic [3:0]  table_number;
        logic        final_res;
    } ewip_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DRAIN,
        ST_MULP,
        ST_MULX,
        ST_RINIT,
        ST_ROOT,
        ST_EMIT
    } ewip_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic mul_load;
        logic mul_sel_x;
        logic store_p;
        logic store_x;
        logic root_init;
        logic root_step;
        logic kern_zero;
        logic kern_sat;
        logic emit;
    } ewip_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic pipe_empty;
        logic norm_zero;
        logic mul_busy;
        logic root_last;
        logic sat;
        logic out_busy;
    } ewip_sts_t;

endpackage

// ----- design/ewip_ctrl.sv -----
// ----------------------------------------------------------------------------
// ewip_ctrl
// Sequencer for end-of-table kernel computation and result hand-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ewip_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 take_eot,
    input  ewip_pkg::ewip_sts_t  sts,
    output ewip_pkg::ewip_cmd_t  cmd,
    output logic                 busy
);

    ewip_pkg::ewip_state_t state_reg, state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ewip_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ewip_pkg::ST_IDLE:
            begin
                if (take_eot)
                begin
                    state_next = ewip_pkg::ST_DRAIN;
                end
            end
            ewip_pkg::ST_DRAIN:
            begin
                if (sts.pipe_empty)
                begin
                    if (sts.norm_zero)
                    begin
                        cmd.kern_zero = 1'b1;
                        state_next    = ewip_pkg::ST_EMIT;
                    end
                    else
                    begin
                        cmd.mul_load = 1'b1;
                        state_next   = ewip_pkg::ST_MULP;
                    end
                end
            end
            ewip_pkg::ST_MULP:
            begin
                if (!sts.mul_busy)
                begin
                    cmd.store_p   = 1'b1;
                    cmd.mul_load  = 1'b1;
                    cmd.mul_sel_x = 1'b1;
                    state_next    = ewip_pkg::ST_MULX;
                end
            end
            ewip_pkg::ST_MULX:
            begin
                if (!sts.mul_busy)
                begin
                    cmd.store_x = 1'b1;
                    state_next  = ewip_pkg::ST_RINIT;
                end
            end
            ewip_pkg::ST_RINIT:
            begin
                if (sts.sat)
                begin
                    cmd.kern_sat = 1'b1;
                    state_next   = ewip_pkg::ST_EMIT;
                end
                else
                begin
                    cmd.root_init = 1'b1;
                    state_next    = ewip_pkg::ST_ROOT;
                end
            end
            ewip_pkg::ST_ROOT:
            begin
                cmd.root_step = 1'b1;
                if (sts.root_last)
                begin
                    state_next = ewip_pkg::ST_EMIT;
                end
            end
            ewip_pkg::ST_EMIT:
            begin
                if (!sts.out_busy)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ewip_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ewip_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ewip_pkg::ST_IDLE);

endmodule

// ----- design/ewip_dpath.sv -----
// ----------------------------------------------------------------------------
// ewip_dpath
// Product pipeline, saturating sums, serial multiplier, root search, output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "entropy_weighted_inner_product_top_macros.svh"

module ewip_dpath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 take,
    input  ewip_pkg::ewip_in_t   item,
    input  ewip_pkg::ewip_cmd_t  cmd,
    output ewip_pkg::ewip_sts_t  sts,
    input  logic                 out_stall,
    output logic                 out_valid,
    output ewip_pkg::ewip_out_t  out_item
);

    localparam int SQ_W    = ewip_pkg::SQ_W;
    localparam int CROSS_W = ewip_pkg::CROSS_W;
    localparam int MUL_W   = ewip_pkg::MUL_W;
    localparam int RW      = ewip_pkg::RW;

    // Product pipeline registers.
    logic        v1_reg, v2_reg;
    logic [15:0] aa1_reg, bb1_reg, ab1_reg, w1_reg;
    logic [15:0] aa2_reg, bb2_reg;
    logic [31:0] abw2_reg;
    logic        eoa_reg;

    // Accumulators.
    logic [SQ_W-1:0]    sa_reg, sb_reg;
    logic [CROSS_W-1:0] sx_reg;
    logic [SQ_W:0]      sa_sum, sb_sum;
    logic [CROSS_W:0]   sx_sum;

    // Serial multiplier.
    logic [2*MUL_W-1:0] mc_reg, prod_reg;
    logic [MUL_W-1:0]   mp_reg;
    logic [ewip_pkg::MCNT_W-1:0] mcnt_reg;
    logic [MUL_W-1:0]   mul_a, mul_b;

    // Root search.
    logic [ewip_pkg::P_W-1:0]  p_reg;
    logic [ewip_pkg::XX_W-1:0] xx_reg;
    logic [RW-1:0] ps_reg, ks_reg, k2p_reg, trial;
    logic [4:0]    rcnt_reg;
    logic [31:0]   kv_reg, kv_bit;
    logic          fit;

    // Result bookkeeping.
    logic [31:0]   min_reg, min_new;
    logic [ewip_pkg::TBL_W-1:0] tcnt_reg;
    logic          ov_reg;
    ewip_pkg::ewip_out_t oi_reg;

    // Stage one: squares and count cross product; stage two: weighting.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            eoa_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= take;
            v2_reg <= v1_reg;
            if (take && item.end_of_table)
            begin
                eoa_reg <= item.end_of_all;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        aa1_reg  <= 16'(item.count_a) * 16'(item.count_a);
        bb1_reg  <= 16'(item.count_b) * 16'(item.count_b);
        ab1_reg  <= 16'(item.count_a) * 16'(item.count_b);
        w1_reg   <= item.bin_weight;
        aa2_reg  <= aa1_reg;
        bb2_reg  <= bb1_reg;
        abw2_reg <= 32'(ab1_reg) * 32'(w1_reg);
    end

    // Saturating accumulation; sums clear when a table's result is emitted.
    assign sa_sum = {1'b0, sa_reg} + (SQ_W + 1)'(aa2_reg);
    assign sb_sum = {1'b0, sb_reg} + (SQ_W + 1)'(bb2_reg);
    assign sx_sum = {1'b0, sx_reg} + (CROSS_W + 1)'(abw2_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sa_reg <= '0;
            sb_reg <= '0;
            sx_reg <= '0;
        end
        else if (cmd.emit)
        begin
            sa_reg <= '0;
            sb_reg <= '0;
            sx_reg <= '0;
        end
        else if (v2_reg)
        begin
            sa_reg <= sa_sum[SQ_W] ? '1 : sa_sum[SQ_W-1:0];
            sb_reg <= sb_sum[SQ_W] ? '1 : sb_sum[SQ_W-1:0];
            sx_reg <= sx_sum[CROSS_W] ? '1 : sx_sum[CROSS_W-1:0];
        end
    end

    // Shift-add multiplier: norm product first, then the scaled cross squared.
    assign mul_a = cmd.mul_sel_x ? {sx_reg, 16'd0} : MUL_W'(sa_reg);
    assign mul_b = cmd.mul_sel_x ? {sx_reg, 16'd0} : MUL_W'(sb_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mcnt_reg <= '0;
        end
        else if (cmd.mul_load)
        begin
            mcnt_reg <= ewip_pkg::MCNT_W'(MUL_W);
        end
        else if (mcnt_reg != '0)
        begin
            mcnt_reg <= mcnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_load)
        begin
            mc_reg   <= (2 * MUL_W)'(mul_a);
            mp_reg   <= mul_b;
            prod_reg <= '0;
        end
        else if (mcnt_reg != '0)
        begin
            if (mp_reg[0])
            begin
                prod_reg <= prod_reg + mc_reg;
            end
            mc_reg <= mc_reg << 1;
            mp_reg <= mp_reg >> 1;
        end
        if (cmd.store_p)
        begin
            p_reg <= ewip_pkg::P_W'(prod_reg);
        end
        if (cmd.store_x)
        begin
            xx_reg <= prod_reg;
        end
    end

    // Bitwise root search on k*k*P <= X*X with running shifted terms.
    assign trial  = k2p_reg + ks_reg + ps_reg;
    assign fit    = (trial <= RW'(xx_reg));
    assign kv_bit = 32'd1 << rcnt_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.root_init)
        begin
            ps_reg   <= RW'(p_reg) << (2 * ewip_pkg::ROOT_TOP);
            ks_reg   <= '0;
            k2p_reg  <= '0;
            rcnt_reg <= 5'(ewip_pkg::ROOT_TOP);
            kv_reg   <= '0;
        end
        else if (cmd.root_step)
        begin
            ps_reg   <= ps_reg >> 2;
            rcnt_reg <= rcnt_reg - 1'b1;
            if (fit)
            begin
                k2p_reg <= trial;
                ks_reg  <= (ks_reg >> 1) + ps_reg;
                kv_reg  <= kv_reg | kv_bit;
            end
            else
            begin
                ks_reg <= ks_reg >> 1;
            end
        end
        else if (cmd.kern_zero)
        begin
            kv_reg <= '0;
        end
        else if (cmd.kern_sat)
        begin
            kv_reg <= ewip_pkg::ONE_Q31;
        end
    end

    // Result register, running minimum and table counter.
    assign min_new = (kv_reg < min_reg) ? kv_reg : min_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg   <= 1'b0;
            min_reg  <= ewip_pkg::ONE_Q31;
            tcnt_reg <= '0;
        end
        else
        begin
            if (cmd.emit)
            begin
                ov_reg <= 1'b1;
                if (eoa_reg)
                begin
                    min_reg  <= ewip_pkg::ONE_Q31;
                    tcnt_reg <= '0;
                end
                else
                begin
                    min_reg <= min_new;
                    if (32'(tcnt_reg) >= ewip_pkg::MAX_TABLES - 1)
                    begin
                        tcnt_reg <= '0;
                    end
                    else
                    begin
                        tcnt_reg <= tcnt_reg + 1'b1;
                    end
                end
            end
            else if (!out_stall)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            oi_reg.table_kernel <= kv_reg;
            oi_reg.min_kernel   <= min_new;
            oi_reg.table_number <= 4'(tcnt_reg);
            oi_reg.final_res    <= eoa_reg;
        end
    end

    assign out_valid = ov_reg;
    assign out_item  = oi_reg;

    // Status to the controller.
    assign sts.pipe_empty = !v1_reg && !v2_reg;
    assign sts.norm_zero  = (sa_reg == '0) || (sb_reg == '0);
    assign sts.mul_busy   = (mcnt_reg != '0);
    assign sts.root_last  = (rcnt_reg == 5'd0);
    assign sts.sat        = ((RW'(p_reg) << 62) <= RW'(xx_reg));
    assign sts.out_busy   = ov_reg && out_stall;

    `EWIP_ASSERT_SAME(a_kern_range, ov_reg, oi_reg.table_kernel <= ewip_pkg::ONE_Q31)
    `EWIP_ASSERT_SAME(a_min_le_kern, ov_reg, oi_reg.min_kernel <= oi_reg.table_kernel)
    `EWIP_ASSERT_SAME(a_no_step_mul, cmd.root_step, mcnt_reg == '0)
    `EWIP_ASSERT_NEXT(a_emit_valid, cmd.emit, ov_reg)

endmodule

// ----- design/entropy_weighted_inner_product_top.sv -----
// A bin that does not end a table passes the stage-one and stage-two registers into the sums.
// A table end gives its result after the serial shift-add multiplier, run twice, and the
// 31-step root search; a zero norm skips both, and a kernel of one or more skips the root
// search. Throughput: one bin per cycle inside a table; the input stalls from a table end
// until its result enters the output register.
// Reset: rst_n asynchronous active low; sums zero, minimum 1.0, counter zero.
// ----------------------------------------------------------------------------
// entropy_weighted_inner_product_top
// Weighted cosine kernel per table with running minimum over tables.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module entropy_weighted_inner_product_top (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 src_valid,
    output logic                 src_stall,
    input  ewip_pkg::ewip_in_t   src_item,
    output logic                 dst_valid,
    input  logic                 dst_stall,
    output ewip_pkg::ewip_out_t  dst_item
);

    ewip_pkg::ewip_cmd_t cmd;
    ewip_pkg::ewip_sts_t sts;
    logic                busy;
    logic                take;

    // A transaction is taken only while the sequencer is idle.
    assign src_stall = busy;
    assign take      = src_valid && !busy;

    ewip_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .take_eot (take && src_item.end_of_table),
        .sts      (sts),
        .cmd      (cmd),
        .busy     (busy)
    );

    ewip_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .item      (src_item),
        .cmd       (cmd),
        .sts       (sts),
        .out_stall (dst_stall),
        .out_valid (dst_valid),
        .out_item  (dst_item)
    );

endmodule
